@@ hw/rtl/aarm_pkg.sv @@
// Shared types, widths and constants for the axis-angle rotation matrix core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package aarm_pkg;

   localparam int AXIS_BITS      = 16;
   localparam int ANGLE_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int OUT_BITS       = 16;

   // normalized axis magnitude: 2^22 < max <= 2^23
   localparam int MAG_BITS       = 24;
   localparam int SQ_BITS        = 48;
   localparam int RAD_BITS       = 62;
   localparam int ROOT_BITS      = 31;
   localparam int SQRT_REM_BITS  = 34;
   localparam int SQRT_STEPS     = RAD_BITS / 2;
   localparam int DIV_BITS       = 32;
   localparam int CORDIC_STEPS   = 30;
   localparam int CXY_BITS       = 33;
   localparam int CZ_BITS        = 32;
   localparam int UNIT_BITS      = 32;

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   typedef struct packed {
      logic signed [AXIS_BITS-1:0] axis_x;
      logic signed [AXIS_BITS-1:0] axis_y;
      logic signed [AXIS_BITS-1:0] axis_z;
      logic [ANGLE_BITS-1:0]       turn_angle;
   } req_data_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] r00;
      logic signed [OUT_BITS-1:0] r01;
      logic signed [OUT_BITS-1:0] r02;
      logic signed [OUT_BITS-1:0] r10;
      logic signed [OUT_BITS-1:0] r11;
      logic signed [OUT_BITS-1:0] r12;
      logic signed [OUT_BITS-1:0] r20;
      logic signed [OUT_BITS-1:0] r21;
      logic signed [OUT_BITS-1:0] r22;
   } rsp_data_type;

   typedef struct packed {
      logic [SQRT_REM_BITS-1:0] rem;
      logic [ROOT_BITS-1:0]     root;
      logic [RAD_BITS-1:0]      rad;
   } sqrt_stage_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] rem;
      logic [DIV_BITS-1:0] num;
      logic [DIV_BITS-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic [DIV_BITS-1:0]     dvs;
      div_lane_type [2:0]      lane;
   } div_stage_type;

   typedef struct packed {
      logic signed [CXY_BITS-1:0] x;
      logic signed [CXY_BITS-1:0] y;
      logic signed [CZ_BITS-1:0]  z;
      logic [1:0]                 quad;
   } cordic_stage_type;

endpackage

@@ hw/rtl/aarm_sqrt_cell.sv @@
// One digit step of the pipelined integer square root (two radicand bits per cell).
// Depends on aarm_pkg.
`timescale 1ns / 1ps

module aarm_sqrt_cell (
   input  logic                     clock,
   input  aarm_pkg::sqrt_stage_type d_in,
   output aarm_pkg::sqrt_stage_type d_ff
);

   aarm_pkg::sqrt_stage_type d_in_next;
   logic [aarm_pkg::SQRT_REM_BITS-1:0] rem_sh;
   logic [aarm_pkg::SQRT_REM_BITS-1:0] trial;

   always_comb begin
      rem_sh = {d_in.rem[aarm_pkg::SQRT_REM_BITS-3:0],
                d_in.rad[aarm_pkg::RAD_BITS-1 -: 2]};
      trial  = aarm_pkg::SQRT_REM_BITS'({d_in.root, 2'b01});
      d_in_next.rad = {d_in.rad[aarm_pkg::RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         d_in_next.rem  = rem_sh - trial;
         d_in_next.root = {d_in.root[aarm_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         d_in_next.rem  = rem_sh;
         d_in_next.root = {d_in.root[aarm_pkg::ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in_next;
   end

endmodule

@@ hw/rtl/aarm_div_cell.sv @@
// One restoring-division step for the three axis lanes (one quotient bit each).
// Depends on aarm_pkg.
`timescale 1ns / 1ps

module aarm_div_cell (
   input  logic                    clock,
   input  aarm_pkg::div_stage_type d_in,
   output aarm_pkg::div_stage_type d_ff
);

   aarm_pkg::div_stage_type d_in_next;
   logic [aarm_pkg::DIV_BITS:0] rem_sh;

   always_comb begin
      d_in_next.dvs = d_in.dvs;
      for (int i = 0; i < 3; i++) begin
         rem_sh = {d_in.lane[i].rem, d_in.lane[i].num[aarm_pkg::DIV_BITS-1]};
         d_in_next.lane[i].num = {d_in.lane[i].num[aarm_pkg::DIV_BITS-2:0], 1'b0};
         if (rem_sh >= {1'b0, d_in.dvs}) begin
            d_in_next.lane[i].rem = aarm_pkg::DIV_BITS'(rem_sh - {1'b0, d_in.dvs});
            d_in_next.lane[i].quo = {d_in.lane[i].quo[aarm_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            d_in_next.lane[i].rem = rem_sh[aarm_pkg::DIV_BITS-1:0];
            d_in_next.lane[i].quo = {d_in.lane[i].quo[aarm_pkg::DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in_next;
   end

endmodule

@@ hw/rtl/aarm_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation; shift and arctangent set per cell.
// Depends on aarm_pkg.
`timescale 1ns / 1ps

module aarm_cordic_cell #(
   parameter int          SHIFT = 0,
   parameter logic [31:0] ATAN  = aarm_pkg::ATAN_TABLE[0]
) (
   input  logic                       clock,
   input  aarm_pkg::cordic_stage_type d_in,
   output aarm_pkg::cordic_stage_type d_ff
);

   aarm_pkg::cordic_stage_type d_in_next;
   logic signed [aarm_pkg::CXY_BITS-1:0] dx;
   logic signed [aarm_pkg::CXY_BITS-1:0] dy;
   logic signed [aarm_pkg::CZ_BITS-1:0]  ang;

   always_comb begin
      dx  = d_in.y >>> SHIFT;
      dy  = d_in.x >>> SHIFT;
      ang = $signed(ATAN);
      d_in_next.quad = d_in.quad;
      if (!d_in.z[aarm_pkg::CZ_BITS-1]) begin
         d_in_next.x = d_in.x - dx;
         d_in_next.y = d_in.y + dy;
         d_in_next.z = d_in.z - ang;
      end else begin
         d_in_next.x = d_in.x + dx;
         d_in_next.y = d_in.y - dy;
         d_in_next.z = d_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in_next;
   end

endmodule

@@ hw/rtl/axis_angle_rotation_matrix_core.sv @@
// Axis-angle (Rodrigues) 3x3 rotation matrix core, row-vector order, Q1.14 out.
// Depth: 71 register stages; the result strobe and the matrix both come from the last one.
// Throughput: one transaction per cycle outside reset, since every cell takes new data each cycle; the
// latency is set by the 31-cell square root and 32-cell divider chains, CORDIC alongside.
// busy is high only while reset is asserted; reset drops all transactions in flight.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  aarm_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output aarm_pkg::rsp_data_type rsp_data
);

   localparam int PIPE_DEPTH = 71;
   localparam int SIDE_DEPTH = 34;   // normalize stage through last root cell
   localparam int SGN_DEPTH  = 33;   // divider setup through last divider cell
   localparam int ANG_DEPTH  = 36;   // aligns CORDIC output with the unit vector
   localparam int F          = aarm_pkg::COEF_FRAC_BITS;

   typedef struct packed {
      logic [2:0][aarm_pkg::MAG_BITS-1:0] mag;
      logic [2:0]                         neg;
      logic                               zero;
   } side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } sgn_type;

   function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + 66'sd536870912;
      return 33'(p >>> 30);
   endfunction

   function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
      logic signed [33:0] lim;
      lim = 34'sd1073741824;
      if (v > lim)
         return 32'(lim);
      if (v < -lim)
         return 32'(-lim);
      return 32'(v);
   endfunction

   function automatic logic [aarm_pkg::OUT_BITS-1:0] to_out(input logic signed [34:0] e);
      logic signed [34:0] v;
      logic signed [34:0] lim;
      lim = 35'sd1 <<< F;
      v   = (e + (35'sd1 <<< (29 - F))) >>> (30 - F);
      if (v > lim)
         v = lim;
      if (v < -lim)
         v = -lim;
      return v[aarm_pkg::OUT_BITS-1:0];
   endfunction

   logic accept;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   // ---------------- axis normalize ----------------
   side_type side_in;
   side_type side_ff [SIDE_DEPTH];
   logic [aarm_pkg::AXIS_BITS:0] mag_in [3];
   logic [aarm_pkg::AXIS_BITS:0] mmax;
   logic [aarm_pkg::AXIS_BITS:0] mm1;
   logic [4:0] bit_len;
   logic [4:0] lsh;
   logic signed [aarm_pkg::AXIS_BITS:0] comp [3];

   always_comb begin
      comp[0] = (aarm_pkg::AXIS_BITS+1)'(req_data.axis_x);
      comp[1] = (aarm_pkg::AXIS_BITS+1)'(req_data.axis_y);
      comp[2] = (aarm_pkg::AXIS_BITS+1)'(req_data.axis_z);
      for (int i = 0; i < 3; i++) begin
         mag_in[i]      = comp[i][aarm_pkg::AXIS_BITS] ? -comp[i] : comp[i];
         side_in.neg[i] = comp[i][aarm_pkg::AXIS_BITS];
      end
      mmax = mag_in[0];
      if (mag_in[1] > mmax)
         mmax = mag_in[1];
      if (mag_in[2] > mmax)
         mmax = mag_in[2];
      side_in.zero = (mmax == '0);
      // shift so that the largest magnitude lands in (2^22, 2^23]
      mm1     = mmax - 1'b1;
      bit_len = '0;
      for (int i = 0; i <= aarm_pkg::AXIS_BITS; i++) begin
         if (mm1[i])
            bit_len = 5'(i + 1);
      end
      lsh = 5'd23 - bit_len;
      for (int i = 0; i < 3; i++) begin
         side_in.mag[i] = aarm_pkg::MAG_BITS'(mag_in[i]) << lsh;
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // ---------------- sum of squares ----------------
   logic [aarm_pkg::SQ_BITS-1:0] sq_ff [3];
   logic [aarm_pkg::SQ_BITS-1:0] n2_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= aarm_pkg::SQ_BITS'(side_ff[0].mag[i]) *
                     aarm_pkg::SQ_BITS'(side_ff[0].mag[i]);
      end
      n2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // ---------------- square root chain ----------------
   aarm_pkg::sqrt_stage_type sq_stage [aarm_pkg::SQRT_STEPS+1];

   assign sq_stage[0] = '{rem: '0, root: '0, rad: {n2_ff, 14'b0}};

   for (genvar k = 0; k < aarm_pkg::SQRT_STEPS; k++) begin : g_sqrt
      aarm_sqrt_cell u_cell (
         .clock (clock),
         .d_in  (sq_stage[k]),
         .d_ff  (sq_stage[k+1])
      );
   end

   // ---------------- divider setup and chain ----------------
   aarm_pkg::div_stage_type div_in;
   aarm_pkg::div_stage_type dv_stage [aarm_pkg::DIV_BITS+1];
   sgn_type sgn_ff [SGN_DEPTH];
   logic [aarm_pkg::RAD_BITS-1:0] numer [3];

   always_comb begin
      div_in.dvs = {sq_stage[aarm_pkg::SQRT_STEPS].root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         numer[i] = {side_ff[SIDE_DEPTH-1].mag[i], 38'b0} +
                    aarm_pkg::RAD_BITS'(sq_stage[aarm_pkg::SQRT_STEPS].root);
         div_in.lane[i].rem = aarm_pkg::DIV_BITS'(numer[i][aarm_pkg::RAD_BITS-1:32]);
         div_in.lane[i].num = numer[i][31:0];
         div_in.lane[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      dv_stage[0] <= div_in;
      sgn_ff[0]   <= '{neg: side_ff[SIDE_DEPTH-1].neg, zero: side_ff[SIDE_DEPTH-1].zero};
      for (int i = 1; i < SGN_DEPTH; i++) begin
         sgn_ff[i] <= sgn_ff[i-1];
      end
   end

   for (genvar k = 0; k < aarm_pkg::DIV_BITS; k++) begin : g_div
      aarm_div_cell u_cell (
         .clock (clock),
         .d_in  (dv_stage[k]),
         .d_ff  (dv_stage[k+1])
      );
   end

   // ---------------- unit vector ----------------
   logic signed [aarm_pkg::UNIT_BITS-1:0] unit_in [3];
   logic signed [aarm_pkg::UNIT_BITS-1:0] unit_ff [3];
   logic [aarm_pkg::DIV_BITS-1:0] qcap;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qcap = dv_stage[aarm_pkg::DIV_BITS].lane[i].quo;
         if (qcap > aarm_pkg::ONE_Q30)
            qcap = aarm_pkg::ONE_Q30;
         if (sgn_ff[SGN_DEPTH-1].zero)
            unit_in[i] = '0;
         else if (sgn_ff[SGN_DEPTH-1].neg[i])
            unit_in[i] = -$signed(qcap);
         else
            unit_in[i] = $signed(qcap);
      end
   end

   // ---------------- angle delay and CORDIC chain ----------------
   logic [aarm_pkg::ANGLE_BITS-1:0] ang_ff [ANG_DEPTH];
   logic [31:0] phase;
   aarm_pkg::cordic_stage_type cor_in;
   aarm_pkg::cordic_stage_type cor_stage [aarm_pkg::CORDIC_STEPS+1];

   always_comb begin
      phase       = {ang_ff[ANG_DEPTH-1], {(32 - aarm_pkg::ANGLE_BITS){1'b0}}};
      cor_in.quad = phase[31:30];
      cor_in.x    = aarm_pkg::CXY_BITS'(aarm_pkg::CORDIC_GAIN);
      cor_in.y    = '0;
      cor_in.z    = $signed({2'b00, phase[29:0]});
   end

   always_ff @(posedge clock) begin
      ang_ff[0] <= req_data.turn_angle;
      for (int i = 1; i < ANG_DEPTH; i++) begin
         ang_ff[i] <= ang_ff[i-1];
      end
      cor_stage[0] <= cor_in;
   end

   for (genvar k = 0; k < aarm_pkg::CORDIC_STEPS; k++) begin : g_cordic
      aarm_cordic_cell #(
         .SHIFT (k),
         .ATAN  (aarm_pkg::ATAN_TABLE[k])
      ) u_cell (
         .clock (clock),
         .d_in  (cor_stage[k]),
         .d_ff  (cor_stage[k+1])
      );
   end

   logic signed [33:0] cx;
   logic signed [33:0] cy;
   logic signed [31:0] cos_in;
   logic signed [31:0] sin_in;
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   always_comb begin
      cx = 34'(cor_stage[aarm_pkg::CORDIC_STEPS].x);
      cy = 34'(cor_stage[aarm_pkg::CORDIC_STEPS].y);
      case (cor_stage[aarm_pkg::CORDIC_STEPS].quad)
         2'd0: begin
            cos_in = clamp_one(cx);
            sin_in = clamp_one(cy);
         end
         2'd1: begin
            cos_in = clamp_one(-cy);
            sin_in = clamp_one(cx);
         end
         2'd2: begin
            cos_in = clamp_one(-cx);
            sin_in = clamp_one(-cy);
         end
         default: begin
            cos_in = clamp_one(cy);
            sin_in = clamp_one(-cx);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         unit_ff[i] <= unit_in[i];
      end
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   // ---------------- products ----------------
   logic signed [32:0] t_q30;
   logic signed [32:0] tu_ff [3];
   logic signed [32:0] su_ff [3];
   logic signed [32:0] up1_ff [3];
   logic signed [31:0] cp1_ff;
   logic signed [32:0] txx_ff, txy_ff, txz_ff, tyy_ff, tyz_ff, tzz_ff;
   logic signed [32:0] sp2_ff [3];
   logic signed [31:0] cp2_ff;

   assign t_q30 = 33'sd1073741824 - 33'(cos_ff);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         tu_ff[i]  <= mulq(t_q30, 33'(unit_ff[i]));
         su_ff[i]  <= mulq(33'(sin_ff), 33'(unit_ff[i]));
         up1_ff[i] <= 33'(unit_ff[i]);
         sp2_ff[i] <= su_ff[i];
      end
      cp1_ff <= cos_ff;
      txx_ff <= mulq(tu_ff[0], up1_ff[0]);
      txy_ff <= mulq(tu_ff[0], up1_ff[1]);
      txz_ff <= mulq(tu_ff[0], up1_ff[2]);
      tyy_ff <= mulq(tu_ff[1], up1_ff[1]);
      tyz_ff <= mulq(tu_ff[1], up1_ff[2]);
      tzz_ff <= mulq(tu_ff[2], up1_ff[2]);
      cp2_ff <= cp1_ff;
   end

   // ---------------- matrix assembly ----------------
   aarm_pkg::rsp_data_type rsp_in;
   aarm_pkg::rsp_data_type rsp_ff;

   always_comb begin
      rsp_in.r00 = to_out(35'(txx_ff) + 35'(cp2_ff));
      rsp_in.r01 = to_out(35'(txy_ff) + 35'(sp2_ff[2]));
      rsp_in.r02 = to_out(35'(txz_ff) - 35'(sp2_ff[1]));
      rsp_in.r10 = to_out(35'(txy_ff) - 35'(sp2_ff[2]));
      rsp_in.r11 = to_out(35'(tyy_ff) + 35'(cp2_ff));
      rsp_in.r12 = to_out(35'(tyz_ff) + 35'(sp2_ff[0]));
      rsp_in.r20 = to_out(35'(txz_ff) + 35'(sp2_ff[1]));
      rsp_in.r21 = to_out(35'(tyz_ff) - 35'(sp2_ff[0]));
      rsp_in.r22 = to_out(35'(tzz_ff) + 35'(cp2_ff));
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

`ifndef SYNTHESIS
   localparam logic signed [aarm_pkg::OUT_BITS-1:0] OUT_ONE = 16'sd1 <<< F;

   a_rsp_from_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result strobe without a matching transaction");

   a_zero_axis_offdiag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.axis_x == '0 && req_data.axis_y == '0 &&
                         req_data.axis_z == '0, PIPE_DEPTH)
      |-> rsp_data.r01 == '0 && rsp_data.r10 == '0 && rsp_data.r12 == '0)
      else $error("zero axis gave nonzero off-diagonal entry");

   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.r00 <= OUT_ONE && rsp_data.r00 >= -OUT_ONE &&
                    rsp_data.r22 <= OUT_ONE && rsp_data.r22 >= -OUT_ONE)
      else $error("diagonal entry out of saturation range");
`endif

endmodule
